@@ hdl/assert_macros.svh @@
// Assertion macros used by the top-level RTL file of the p-code execution core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain invariant, checked at every clock edge outside reset.
`define PCSM_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define PCSM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PCSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/pcsm_pkg.sv @@
// Package with field widths, opcodes, operator codes and fault codes of the p-code core.
`timescale 1ns / 1ps
package pcsm_pkg;

  localparam int CMD_W    = 3;
  localparam int LEVEL_W  = 4;
  localparam int WORD_W   = 32;
  localparam int PC_OUT_W = 12;
  localparam int FAULT_W  = 2;
  // Index arithmetic is done at this width so that a word plus an operand never overflows.
  localparam int ARITH_W  = 34;

  typedef logic [WORD_W-1:0] word_t;

  localparam logic [CMD_W-1:0] CMD_LIT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_OPR = 3'd1;
  localparam logic [CMD_W-1:0] CMD_LOD = 3'd2;
  localparam logic [CMD_W-1:0] CMD_STO = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CAL = 3'd4;
  localparam logic [CMD_W-1:0] CMD_INT = 3'd5;
  localparam logic [CMD_W-1:0] CMD_JMP = 3'd6;
  localparam logic [CMD_W-1:0] CMD_JPC = 3'd7;

  localparam word_t OPR_RET = 32'd0;
  localparam word_t OPR_NEG = 32'd1;
  localparam word_t OPR_ADD = 32'd2;
  localparam word_t OPR_SUB = 32'd3;
  localparam word_t OPR_MUL = 32'd4;
  localparam word_t OPR_DIV = 32'd5;
  localparam word_t OPR_ODD = 32'd6;
  localparam word_t OPR_EQ  = 32'd8;
  localparam word_t OPR_NE  = 32'd9;
  localparam word_t OPR_LT  = 32'd10;
  localparam word_t OPR_GE  = 32'd11;
  localparam word_t OPR_GT  = 32'd12;
  localparam word_t OPR_LE  = 32'd13;

  localparam logic [FAULT_W-1:0] FAULT_NONE  = 2'd0;
  localparam logic [FAULT_W-1:0] FAULT_RANGE = 2'd1;
  localparam logic [FAULT_W-1:0] FAULT_DIV0  = 2'd2;
  localparam logic [FAULT_W-1:0] FAULT_JUMP  = 2'd3;

  // A call frame holds static link, dynamic link and return address.
  localparam int FRAME_WORDS = 3;

endpackage

@@ hdl/pcsm_ifs.sv @@
// Valid/ready channel interfaces for instructions in and results out.
`timescale 1ns / 1ps
interface pcsm_in_if;
  logic                               valid;
  logic                               ready;
  logic [pcsm_pkg::CMD_W-1:0]         cmd;
  logic [pcsm_pkg::LEVEL_W-1:0]       level;
  logic signed [pcsm_pkg::WORD_W-1:0] operand;

  modport source(output valid, output cmd, output level, output operand, input ready);
  modport sink(input valid, input cmd, input level, input operand, output ready);
endinterface

interface pcsm_out_if;
  logic                               valid;
  logic                               ready;
  logic [pcsm_pkg::PC_OUT_W-1:0]      next_pc;
  logic signed [pcsm_pkg::WORD_W-1:0] stored_value;
  logic                               store_valid;
  logic                               halted;
  logic [pcsm_pkg::FAULT_W-1:0]       fault;

  modport source(output valid, output next_pc, output stored_value, output store_valid,
                 output halted, output fault, input ready);
  modport sink(input valid, input next_pc, input stored_value, input store_valid,
               input halted, input fault, output ready);
endinterface

@@ hdl/pcsm_div.sv @@
// Signed 32-bit radix-2 divider, truncating toward zero, one quotient bit per cycle.
`timescale 1ns / 1ps
module pcsm_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  pcsm_pkg::word_t    dividend,
  input  pcsm_pkg::word_t    divisor,
  output logic               done,
  output pcsm_pkg::word_t    quotient
);

  localparam int STEPS = pcsm_pkg::WORD_W;
  localparam int CW    = $clog2(STEPS + 1);

  logic [pcsm_pkg::WORD_W:0]   rem_r;
  pcsm_pkg::word_t             quo_r;
  pcsm_pkg::word_t             dvs_r;
  logic [CW-1:0]               cnt_r;
  logic                        neg_r;
  logic                        busy_r;
  logic                        done_r;
  logic [pcsm_pkg::WORD_W:0]   shifted;
  logic [pcsm_pkg::WORD_W:0]   diff;

  assign shifted = {rem_r[pcsm_pkg::WORD_W-1:0], quo_r[pcsm_pkg::WORD_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CW'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Work on magnitudes; the most negative value maps to itself as an unsigned magnitude.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend[pcsm_pkg::WORD_W-1] ? (~dividend + 1'b1) : dividend;
      dvs_r <= divisor[pcsm_pkg::WORD_W-1] ? (~divisor + 1'b1) : divisor;
      neg_r <= dividend[pcsm_pkg::WORD_W-1] ^ divisor[pcsm_pkg::WORD_W-1];
    end else if (busy_r) begin
      if (!diff[pcsm_pkg::WORD_W]) begin
        rem_r <= diff;
        quo_r <= {quo_r[pcsm_pkg::WORD_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted;
        quo_r <= {quo_r[pcsm_pkg::WORD_W-2:0], 1'b0};
      end
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? (~quo_r + 1'b1) : quo_r;

endmodule

@@ hdl/pcode_stack_machine_execute.sv @@
// Top level of the p-code execution core: sequencer around one stack memory.
// An instruction steps through walk (per static level), address check, operand reads A
// and B, execute, divide (OPR DIV only), write-back and done; a level over MAX_LEVEL or a
// range or target fault caught before the operand reads goes straight to done. It is one
// instruction at a time on the single stack read port; the result register frees input.
// Reset (synchronous, rst_n low) clears top to 0, base to 1, pc to 0, then a clearing pass
// over all STACK_DEPTH words zeroes the stack memory before the first instruction is taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pcode_stack_machine_execute #(
  parameter int STACK_DEPTH = 512,
  parameter int CODE_DEPTH  = 4096,
  parameter int MAX_LEVEL   = 15
) (
  input logic        clk,
  input logic        rst_n,
  pcsm_in_if.sink    in_chan,
  pcsm_out_if.source out_chan
);

  localparam int SW = $clog2(STACK_DEPTH);
  localparam int PW = $clog2(CODE_DEPTH);
  localparam int AW = pcsm_pkg::ARITH_W;
  localparam int LW = pcsm_pkg::LEVEL_W;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_WALK  = 4'd2;
  localparam logic [3:0] S_WALKW = 4'd3;
  localparam logic [3:0] S_ADDR  = 4'd4;
  localparam logic [3:0] S_RA    = 4'd5;
  localparam logic [3:0] S_RB    = 4'd6;
  localparam logic [3:0] S_EXEC  = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_WB    = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  function automatic logic in_stack(input logic signed [AW-1:0] v);
    return (v >= 0) && (v < $signed(AW'(STACK_DEPTH)));
  endfunction

  function automatic logic in_code(input pcsm_pkg::word_t w);
    return !w[pcsm_pkg::WORD_W-1] && ({1'b0, w} < 33'(CODE_DEPTH));
  endfunction

  // Stack memory, one write and one registered read per cycle.
  pcsm_pkg::word_t mem [STACK_DEPTH];
  logic            mem_we;
  logic [SW-1:0]   mem_waddr;
  pcsm_pkg::word_t mem_wdata;
  logic [SW-1:0]   mem_raddr;
  pcsm_pkg::word_t rdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  logic [3:0]                       state_r, state_nxt;
  logic [SW-1:0]                    clr_addr_r;
  logic [SW-1:0]                    t_r, b_r;
  logic [PW-1:0]                    pc_r;
  logic [pcsm_pkg::CMD_W-1:0]       cmd_r;
  logic [LW-1:0]                    lvl_cnt_r;
  pcsm_pkg::word_t                  op_r, fb_r, x_r, y_r, r_r;
  logic [pcsm_pkg::FAULT_W-1:0]     fault_r;
  logic [SW-1:0]                    nt_r, nb_r;
  logic [PW-1:0]                    npc_r;
  logic [1:0]                       wcnt_r;

  logic                             out_valid_r;
  logic [pcsm_pkg::PC_OUT_W-1:0]    out_pc_r;
  pcsm_pkg::word_t                  out_stored_r;
  logic                             out_store_valid_r;
  logic                             out_halted_r;
  logic [pcsm_pkg::FAULT_W-1:0]     out_fault_r;

  logic signed [AW-1:0] t_s, b_s, op_s, fb_s;
  logic signed [AW-1:0] t_p1, t_p3, t_m1, b_m1, b_p1, b_p2, idx_s, t_op;
  logic [PW-1:0]        pc_inc;
  logic                 is_ret, is_unary, is_binary, is_div;
  logic                 need_walk;
  logic [1:0]           nwrites;
  logic                 fault_a;
  logic [pcsm_pkg::FAULT_W-1:0] fault_a_code;
  logic                 div_start, div_done;
  pcsm_pkg::word_t      div_q;
  logic                 in_xfer, out_free;
  logic [PW-1:0]        fin_pc;
  logic [SW-1:0]        ex_nt, ex_nb;
  logic [PW-1:0]        ex_npc;
  pcsm_pkg::word_t      ex_r;
  logic                 ex_fault;
  logic [pcsm_pkg::FAULT_W-1:0] ex_fault_code;

  assign t_s   = $signed(AW'(t_r));
  assign b_s   = $signed(AW'(b_r));
  assign op_s  = AW'($signed(op_r));
  assign fb_s  = AW'($signed(fb_r));
  assign t_p1  = t_s + AW'(1);
  assign t_p3  = t_s + AW'(pcsm_pkg::FRAME_WORDS);
  assign t_m1  = t_s - AW'(1);
  assign b_m1  = b_s - AW'(1);
  assign b_p1  = b_s + AW'(1);
  assign b_p2  = b_s + AW'(2);
  assign idx_s = fb_s + op_s;
  assign t_op  = t_s + op_s;

  assign pc_inc = (pc_r == PW'(CODE_DEPTH - 1)) ? '0 : pc_r + 1'b1;

  assign is_ret    = (op_r == pcsm_pkg::OPR_RET);
  assign is_unary  = (op_r == pcsm_pkg::OPR_NEG) || (op_r == pcsm_pkg::OPR_ODD);
  assign is_binary = op_r inside {[pcsm_pkg::OPR_ADD:pcsm_pkg::OPR_DIV],
                                  [pcsm_pkg::OPR_EQ:pcsm_pkg::OPR_LE]};
  assign is_div    = (op_r == pcsm_pkg::OPR_DIV);

  assign need_walk = (in_chan.cmd == pcsm_pkg::CMD_LOD) || (in_chan.cmd == pcsm_pkg::CMD_STO) ||
                     (in_chan.cmd == pcsm_pkg::CMD_CAL);

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_xfer       = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;

  // Range and target checks that depend only on registers, before any operand read.
  always_comb begin
    fault_a      = 1'b0;
    fault_a_code = pcsm_pkg::FAULT_RANGE;
    case (cmd_r)
      pcsm_pkg::CMD_LIT: fault_a = !in_stack(t_p1);
      pcsm_pkg::CMD_OPR: begin
        if (is_ret) begin
          fault_a = !in_stack(b_m1) || !in_stack(b_p2);
        end else if (is_unary) begin
          fault_a = !in_stack(t_s);
        end else if (is_binary) begin
          fault_a = !in_stack(t_s) || !in_stack(t_m1);
        end
      end
      pcsm_pkg::CMD_LOD: fault_a = !in_stack(idx_s) || !in_stack(t_p1);
      pcsm_pkg::CMD_STO: fault_a = !in_stack(idx_s) || !in_stack(t_s) || !in_stack(t_m1);
      pcsm_pkg::CMD_CAL: begin
        if (!in_stack(t_p1) || !in_stack(t_p3)) begin
          fault_a = 1'b1;
        end else if (!in_code(op_r)) begin
          fault_a      = 1'b1;
          fault_a_code = pcsm_pkg::FAULT_JUMP;
        end
      end
      pcsm_pkg::CMD_INT: fault_a = !in_stack(t_op);
      pcsm_pkg::CMD_JMP: begin
        fault_a      = !in_code(op_r);
        fault_a_code = pcsm_pkg::FAULT_JUMP;
      end
      pcsm_pkg::CMD_JPC: fault_a = !in_stack(t_s) || !in_stack(t_m1);
      default: fault_a = 1'b0;
    endcase
  end

  always_comb begin
    case (cmd_r)
      pcsm_pkg::CMD_CAL: nwrites = 2'd3;
      pcsm_pkg::CMD_LIT, pcsm_pkg::CMD_LOD, pcsm_pkg::CMD_STO: nwrites = 2'd1;
      pcsm_pkg::CMD_OPR: nwrites = (is_unary || is_binary) ? 2'd1 : 2'd0;
      default: nwrites = 2'd0;
    endcase
  end

  // Read address: walk link, then operand A, then operand B.
  always_comb begin
    mem_raddr = t_s[SW-1:0];
    case (state_r)
      S_WALK: mem_raddr = fb_r[SW-1:0];
      S_ADDR: begin
        if (cmd_r == pcsm_pkg::CMD_OPR && is_ret) begin
          mem_raddr = b_p2[SW-1:0];
        end else if (cmd_r == pcsm_pkg::CMD_OPR && is_binary) begin
          mem_raddr = t_m1[SW-1:0];
        end else if (cmd_r == pcsm_pkg::CMD_LOD) begin
          mem_raddr = idx_s[SW-1:0];
        end
      end
      S_RA: begin
        if (cmd_r == pcsm_pkg::CMD_OPR && is_ret) begin
          mem_raddr = b_p1[SW-1:0];
        end
      end
      default: mem_raddr = t_s[SW-1:0];
    endcase
  end

  // Write port: clearing sweep or write-back of the instruction.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr_r;
    mem_wdata = '0;
    if (state_r == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (state_r == S_WB) begin
      mem_we = 1'b1;
      case (cmd_r)
        pcsm_pkg::CMD_LIT: begin
          mem_waddr = t_p1[SW-1:0];
          mem_wdata = op_r;
        end
        pcsm_pkg::CMD_OPR: begin
          mem_waddr = is_binary ? t_m1[SW-1:0] : t_r;
          mem_wdata = r_r;
        end
        pcsm_pkg::CMD_LOD: begin
          mem_waddr = t_p1[SW-1:0];
          mem_wdata = x_r;
        end
        pcsm_pkg::CMD_STO: begin
          mem_waddr = idx_s[SW-1:0];
          mem_wdata = x_r;
        end
        pcsm_pkg::CMD_CAL: begin
          mem_waddr = t_r + SW'(wcnt_r) + 1'b1;
          case (wcnt_r)
            2'd0:    mem_wdata = fb_r;
            2'd1:    mem_wdata = pcsm_pkg::WORD_W'(b_r);
            default: mem_wdata = pcsm_pkg::WORD_W'(pc_inc);
          endcase
        end
        default: mem_we = 1'b0;
      endcase
    end
  end

  // Execute stage: new top, base and pc, the operator result and late faults.
  always_comb begin
    ex_nt         = t_r;
    ex_nb         = b_r;
    ex_npc        = pc_inc;
    ex_r          = '0;
    ex_fault      = 1'b0;
    ex_fault_code = pcsm_pkg::FAULT_RANGE;
    case (cmd_r)
      pcsm_pkg::CMD_LIT: ex_nt = t_p1[SW-1:0];
      pcsm_pkg::CMD_OPR: begin
        if (is_ret) begin
          if (!in_stack(AW'($signed(y_r)))) begin
            ex_fault = 1'b1;
          end else if (!in_code(x_r)) begin
            ex_fault      = 1'b1;
            ex_fault_code = pcsm_pkg::FAULT_JUMP;
          end
          ex_nt  = b_m1[SW-1:0];
          ex_nb  = y_r[SW-1:0];
          ex_npc = x_r[PW-1:0];
        end else if (is_binary) begin
          ex_nt = t_m1[SW-1:0];
          case (op_r)
            pcsm_pkg::OPR_ADD: ex_r = x_r + y_r;
            pcsm_pkg::OPR_SUB: ex_r = x_r - y_r;
            pcsm_pkg::OPR_MUL: ex_r = x_r * y_r;
            pcsm_pkg::OPR_DIV: begin
              if (y_r == '0) begin
                ex_fault      = 1'b1;
                ex_fault_code = pcsm_pkg::FAULT_DIV0;
              end
            end
            pcsm_pkg::OPR_EQ:  ex_r = pcsm_pkg::WORD_W'(x_r == y_r);
            pcsm_pkg::OPR_NE:  ex_r = pcsm_pkg::WORD_W'(x_r != y_r);
            pcsm_pkg::OPR_LT:  ex_r = pcsm_pkg::WORD_W'($signed(x_r) < $signed(y_r));
            pcsm_pkg::OPR_GE:  ex_r = pcsm_pkg::WORD_W'($signed(x_r) >= $signed(y_r));
            pcsm_pkg::OPR_GT:  ex_r = pcsm_pkg::WORD_W'($signed(x_r) > $signed(y_r));
            default:           ex_r = pcsm_pkg::WORD_W'($signed(x_r) <= $signed(y_r));
          endcase
        end else if (op_r == pcsm_pkg::OPR_NEG) begin
          ex_r = '0 - x_r;
        end else begin
          ex_r = pcsm_pkg::WORD_W'(x_r[0]);
        end
      end
      pcsm_pkg::CMD_LOD: ex_nt = t_p1[SW-1:0];
      pcsm_pkg::CMD_STO: ex_nt = t_m1[SW-1:0];
      pcsm_pkg::CMD_CAL: begin
        ex_nb  = t_p1[SW-1:0];
        ex_npc = op_r[PW-1:0];
      end
      pcsm_pkg::CMD_INT: ex_nt = t_op[SW-1:0];
      pcsm_pkg::CMD_JMP: ex_npc = op_r[PW-1:0];
      pcsm_pkg::CMD_JPC: begin
        ex_nt = t_m1[SW-1:0];
        if (x_r == '0) begin
          if (!in_code(op_r)) begin
            ex_fault      = 1'b1;
            ex_fault_code = pcsm_pkg::FAULT_JUMP;
          end
          ex_npc = op_r[PW-1:0];
        end
      end
      default: ex_nt = t_r;
    endcase
  end

  assign div_start = (state_r == S_EXEC) && (cmd_r == pcsm_pkg::CMD_OPR) && is_div &&
                     (y_r != '0);

  pcsm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (x_r),
    .divisor  (y_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_addr_r == SW'(STACK_DEPTH - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_xfer) begin
          if (need_walk && int'(in_chan.level) > MAX_LEVEL) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (lvl_cnt_r == '0) begin
          state_nxt = S_ADDR;
        end else if (!in_stack(fb_s)) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_WALKW;
        end
      end
      S_WALKW: state_nxt = S_WALK;
      S_ADDR:  state_nxt = fault_a ? S_DONE : S_RA;
      S_RA:    state_nxt = S_RB;
      S_RB:    state_nxt = S_EXEC;
      S_EXEC: begin
        if (div_start) begin
          state_nxt = S_DIV;
        end else if (cmd_r == pcsm_pkg::CMD_OPR && is_div) begin
          state_nxt = S_DONE;
        end else if (nwrites == 2'd0) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_WB;
        end
      end
      S_DIV: if (div_done) state_nxt = S_WB;
      S_WB:  if (wcnt_r == nwrites - 2'd1) state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_addr_r <= '0;
      t_r        <= '0;
      b_r        <= SW'(1);
      pc_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (state_r == S_DONE && out_free && fault_r == pcsm_pkg::FAULT_NONE) begin
        t_r  <= nt_r;
        b_r  <= nb_r;
        pc_r <= npc_r;
      end
    end
  end

  // Working registers of the instruction in flight.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        cmd_r     <= in_chan.cmd;
        op_r      <= in_chan.operand;
        fb_r      <= pcsm_pkg::WORD_W'(b_r);
        lvl_cnt_r <= need_walk ? in_chan.level : '0;
        wcnt_r    <= '0;
        fault_r   <= (need_walk && int'(in_chan.level) > MAX_LEVEL) ? pcsm_pkg::FAULT_RANGE
                                                                    : pcsm_pkg::FAULT_NONE;
      end
      S_WALK: begin
        if (lvl_cnt_r != '0 && !in_stack(fb_s)) begin
          fault_r <= pcsm_pkg::FAULT_RANGE;
        end
      end
      S_WALKW: begin
        fb_r      <= rdata_r;
        lvl_cnt_r <= lvl_cnt_r - 1'b1;
      end
      S_ADDR: begin
        if (fault_a) begin
          fault_r <= fault_a_code;
        end
      end
      S_RA: x_r <= rdata_r;
      S_RB: y_r <= rdata_r;
      S_EXEC: begin
        nt_r  <= ex_nt;
        nb_r  <= ex_nb;
        npc_r <= ex_npc;
        r_r   <= ex_r;
        if (ex_fault) begin
          fault_r <= ex_fault_code;
        end
      end
      S_DIV: if (div_done) r_r <= div_q;
      S_WB:  wcnt_r <= wcnt_r + 1'b1;
      default: wcnt_r <= wcnt_r;
    endcase
  end

  assign fin_pc = (fault_r == pcsm_pkg::FAULT_NONE) ? npc_r : pc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_pc_r          <= pcsm_pkg::PC_OUT_W'(32'(fin_pc));
      out_fault_r       <= fault_r;
      out_store_valid_r <= (fault_r == pcsm_pkg::FAULT_NONE) && (cmd_r == pcsm_pkg::CMD_STO);
      out_stored_r      <= ((fault_r == pcsm_pkg::FAULT_NONE) && (cmd_r == pcsm_pkg::CMD_STO))
                           ? x_r : '0;
      out_halted_r      <= (fault_r == pcsm_pkg::FAULT_NONE) && (npc_r == '0);
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.next_pc      = out_pc_r;
  assign out_chan.stored_value = out_stored_r;
  assign out_chan.store_valid  = out_store_valid_r;
  assign out_chan.halted       = out_halted_r;
  assign out_chan.fault        = out_fault_r;

  `PCSM_ASSERT(a_top_range, int'(t_r) < STACK_DEPTH, "top index left the stack")
  `PCSM_ASSERT_IMPL(a_fault_quiet, out_valid_r && out_fault_r != pcsm_pkg::FAULT_NONE, !out_store_valid_r && !out_halted_r, "faulting result reports a store or halt")
  `PCSM_ASSERT_IMPL(a_write_owner, mem_we, state_r == S_WB || state_r == S_CLEAR, "stack written outside write-back or clearing")
  `PCSM_ASSERT_NEXT(a_accept_busy, in_xfer, state_r != S_IDLE, "core stayed idle after an instruction transfer")

endmodule

@@ test/pcode_stack_machine_execute_tb.sv @@
// Self-checking testbench for the p-code execution core: predicted results against the block.
`timescale 1ns / 1ps
module pcode_stack_machine_execute_tb;
  import pcsm_pkg::*;

  localparam int STACK_N = 512;
  localparam int CODE_N = 4096;
  localparam int LEVEL_MAX = 15;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [PC_OUT_W-1:0] next_pc;
    word_t stored_value;
    logic store_valid;
    logic halted;
    logic [FAULT_W-1:0] fault;
  } exec_result_t;

  class exec_scoreboard;
    word_t stack_mem[STACK_N];
    longint top_idx;
    longint base_idx;
    longint pc_reg;
    exec_result_t pending[$];
    int mismatches;
    int executed;
    int checked;
    int fault_hits[4];

    function void clear_state();
      foreach (stack_mem[i]) stack_mem[i] = '0;
      top_idx = 0;
      base_idx = 1;
      pc_reg = 0;
    endfunction

    function bit in_stack(longint i);
      return i >= 0 && i < STACK_N;
    endfunction

    // Follows static links from the current base; a zero return flags a range fault.
    function bit walk_links(int unsigned levels, output longint frame);
      longint b;
      b = base_idx;
      frame = 0;
      if (levels > LEVEL_MAX) return 0;
      for (int n = 0; n < levels; n++) begin
        if (!in_stack(b)) return 0;
        b = longint'($signed(stack_mem[b]));
      end
      frame = b;
      return 1;
    endfunction

    function void note_instruction(logic [CMD_W-1:0] cmd, logic [LEVEL_W-1:0] level,
                                   word_t opw);
      longint t, b, pc, fb, idx, op, npc, nb;
      word_t x, y, r, stored;
      logic stv;
      logic [FAULT_W-1:0] flt;
      exec_result_t res;
      t = top_idx;
      b = base_idx;
      pc = (pc_reg + 1) % CODE_N;
      op = longint'($signed(opw));
      stored = '0;
      stv = 0;
      flt = FAULT_NONE;
      fb = 0;
      r = '0;
      case (cmd)
        CMD_LIT: begin
          if (!in_stack(t + 1)) flt = FAULT_RANGE;
          else begin
            t = t + 1;
            stack_mem[t] = opw;
          end
        end
        CMD_OPR: begin
          if (opw == OPR_RET) begin
            if (!in_stack(b - 1) || !in_stack(b + 2)) flt = FAULT_RANGE;
            else begin
              npc = longint'($signed(stack_mem[b + 2]));
              nb = longint'($signed(stack_mem[b + 1]));
              if (!in_stack(nb)) flt = FAULT_RANGE;
              else if (npc < 0 || npc >= CODE_N) flt = FAULT_JUMP;
              else begin
                t = b - 1;
                pc = npc;
                b = nb;
              end
            end
          end else if (opw == OPR_NEG || opw == OPR_ODD) begin
            if (!in_stack(t)) flt = FAULT_RANGE;
            else begin
              x = stack_mem[t];
              stack_mem[t] = (opw == OPR_NEG) ? -x : {31'd0, x[0]};
            end
          end else if ((op >= OPR_ADD && op <= OPR_DIV) || (op >= OPR_EQ && op <= OPR_LE)) begin
            if (!in_stack(t) || !in_stack(t - 1)) flt = FAULT_RANGE;
            else begin
              x = stack_mem[t - 1];
              y = stack_mem[t];
              case (opw)
                OPR_ADD: r = x + y;
                OPR_SUB: r = x - y;
                OPR_MUL: r = x * y;
                OPR_DIV: begin
                  if (y == '0) flt = FAULT_DIV0;
                  else r = word_t'(longint'($signed(x)) / longint'($signed(y)));
                end
                OPR_EQ: r = word_t'(x == y);
                OPR_NE: r = word_t'(x != y);
                OPR_LT: r = word_t'($signed(x) < $signed(y));
                OPR_GE: r = word_t'($signed(x) >= $signed(y));
                OPR_GT: r = word_t'($signed(x) > $signed(y));
                default: r = word_t'($signed(x) <= $signed(y));
              endcase
              if (flt == FAULT_NONE) begin
                t = t - 1;
                stack_mem[t] = r;
              end
            end
          end
        end
        CMD_LOD: begin
          if (!walk_links(level, fb)) flt = FAULT_RANGE;
          else begin
            idx = fb + op;
            if (!in_stack(idx) || !in_stack(t + 1)) flt = FAULT_RANGE;
            else begin
              t = t + 1;
              stack_mem[t] = stack_mem[idx];
            end
          end
        end
        CMD_STO: begin
          if (!walk_links(level, fb)) flt = FAULT_RANGE;
          else begin
            idx = fb + op;
            if (!in_stack(idx) || !in_stack(t) || !in_stack(t - 1)) flt = FAULT_RANGE;
            else begin
              stored = stack_mem[t];
              stv = 1;
              stack_mem[idx] = stored;
              t = t - 1;
            end
          end
        end
        CMD_CAL: begin
          if (!walk_links(level, fb) || !in_stack(t + 1) || !in_stack(t + 3)) flt = FAULT_RANGE;
          else if (op < 0 || op >= CODE_N) flt = FAULT_JUMP;
          else begin
            stack_mem[t + 1] = word_t'(fb);
            stack_mem[t + 2] = word_t'(b);
            stack_mem[t + 3] = word_t'(pc);
            b = t + 1;
            pc = op;
          end
        end
        CMD_INT: begin
          if (!in_stack(t + op)) flt = FAULT_RANGE;
          else t = t + op;
        end
        CMD_JMP: begin
          if (op < 0 || op >= CODE_N) flt = FAULT_JUMP;
          else pc = op;
        end
        default: begin
          if (!in_stack(t) || !in_stack(t - 1)) flt = FAULT_RANGE;
          else if (stack_mem[t] == '0 && (op < 0 || op >= CODE_N)) flt = FAULT_JUMP;
          else begin
            if (stack_mem[t] == '0) pc = op;
            t = t - 1;
          end
        end
      endcase
      // A faulting instruction leaves every register as it was.
      if (flt != FAULT_NONE) begin
        res = '{next_pc: pc_reg[PC_OUT_W-1:0], stored_value: '0, store_valid: 0,
                halted: 0, fault: flt};
      end else begin
        top_idx = t;
        base_idx = b;
        pc_reg = pc;
        res = '{next_pc: pc[PC_OUT_W-1:0], stored_value: stored, store_valid: stv,
                halted: (pc == 0), fault: FAULT_NONE};
      end
      fault_hits[flt]++;
      executed++;
      pending.push_back(res);
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      $display("MISMATCH result %0d %s: got %0h, expected %0h", checked, what, got, want);
    endtask

    task check_result(exec_result_t got);
      exec_result_t want;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result", got, 0);
        return;
      end
      want = pending.pop_front();
      if (got.next_pc !== want.next_pc) report_mismatch("next_pc", got.next_pc, want.next_pc);
      if (got.stored_value !== want.stored_value)
        report_mismatch("stored_value", got.stored_value, want.stored_value);
      if (got.store_valid !== want.store_valid)
        report_mismatch("store_valid", got.store_valid, want.store_valid);
      if (got.halted !== want.halted) report_mismatch("halted", got.halted, want.halted);
      if (got.fault !== want.fault) report_mismatch("fault", got.fault, want.fault);
      checked++;
    endtask
  endclass

  logic clk;
  logic rst_n;
  pcsm_in_if in_chan();
  pcsm_out_if out_chan();

  pcode_stack_machine_execute dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_chan),
    .out_chan(out_chan)
  );

  exec_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  bit recv_hold;
  int unsigned cycle_count = 0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               sb.pending.size());
      $display("pcode_stack_machine_execute verification failed");
      $finish;
    end
  end

  // Result side: check every transfer, then decide whether to be ready next cycle.
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready)
      sb.check_result('{next_pc: out_chan.next_pc, stored_value: out_chan.stored_value,
                        store_valid: out_chan.store_valid, halted: out_chan.halted,
                        fault: out_chan.fault});
    out_chan.ready <= rst_n && !recv_hold && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task send_instr(logic [CMD_W-1:0] cmd, logic [LEVEL_W-1:0] level, word_t opw);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.cmd <= cmd;
    in_chan.level <= level;
    in_chan.operand <= opw;
    do @(posedge clk); while (!in_chan.ready);
    sb.note_instruction(cmd, level, opw);
  endtask

  function word_t pick_literal();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return word_t'($urandom_range(0, 3));
    if (r < 45) return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    if (r < 55) return -word_t'($urandom_range(1, 3));
    return $urandom;
  endfunction

  function word_t pick_target();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return word_t'(CODE_N + $urandom_range(0, 3));
    if (r < 12) return $urandom;
    if (r < 20) return '0;
    return word_t'($urandom_range(1, CODE_N - 1));
  endfunction

  // Mostly well-formed programs around the current top, with some noise mixed in.
  task send_random_instr();
    int unsigned r;
    word_t sub;
    r = $urandom_range(0, 99);
    if (sb.top_idx > STACK_N - 40) begin
      send_instr(CMD_INT, '0, -word_t'($urandom_range(1, 200)));
    end else if (r < 26) begin
      send_instr(CMD_LIT, '0, pick_literal());
    end else if (r < 48) begin
      case ($urandom_range(0, 14))
        0: sub = OPR_RET;
        1: sub = OPR_NEG;
        2: sub = OPR_ADD;
        3: sub = OPR_SUB;
        4: sub = OPR_MUL;
        5, 6: sub = OPR_DIV;
        7: sub = OPR_ODD;
        8: sub = OPR_EQ;
        9: sub = OPR_NE;
        10: sub = OPR_LT;
        11: sub = OPR_GE;
        12: sub = OPR_GT;
        13: sub = OPR_LE;
        default: sub = $urandom_range(0, 1) ? 32'd7 : $urandom;
      endcase
      send_instr(CMD_OPR, '0, sub);
    end else if (r < 58) begin
      send_instr(CMD_LOD, LEVEL_W'($urandom_range(0, 2)), word_t'($urandom_range(0, 8)) - 3);
    end else if (r < 67) begin
      send_instr(CMD_STO, LEVEL_W'($urandom_range(0, 2)), word_t'($urandom_range(0, 8)) - 3);
    end else if (r < 74) begin
      send_instr(CMD_CAL, LEVEL_W'($urandom_range(0, 1)), pick_target());
    end else if (r < 80) begin
      send_instr(CMD_INT, '0, word_t'($urandom_range(0, 8)) - 2);
    end else if (r < 86) begin
      send_instr(CMD_JMP, LEVEL_W'($urandom), pick_target());
    end else if (r < 93) begin
      send_instr(CMD_JPC, LEVEL_W'($urandom), pick_target());
    end else begin
      send_instr(CMD_W'($urandom), LEVEL_W'($urandom), $urandom);
    end
  endtask

  task send_directed();
    send_instr(CMD_LIT, '0, 32'h7FFF_FFFF);
    send_instr(CMD_LIT, '0, 32'h0000_0001);
    send_instr(CMD_OPR, '0, OPR_ADD);
    send_instr(CMD_LIT, '0, 32'hFFFF_FFFF);
    send_instr(CMD_OPR, '0, OPR_DIV);
    send_instr(CMD_OPR, '0, OPR_ODD);
    send_instr(CMD_OPR, '0, OPR_NEG);
    send_instr(CMD_LIT, '0, '0);
    send_instr(CMD_OPR, '0, OPR_DIV);
    send_instr(CMD_LIT, '0, 32'hFFFF_FFF9);
    send_instr(CMD_OPR, '0, OPR_MUL);
    send_instr(CMD_OPR, '0, 32'd7);
    send_instr(CMD_LIT, '0, 32'h8000_0000);
    send_instr(CMD_OPR, '0, OPR_LT);
    send_instr(CMD_STO, '0, 32'd0);
    send_instr(CMD_LOD, 4'd15, 32'd0);
    send_instr(CMD_INT, '0, 32'hFFFF_FF00);
    send_instr(CMD_CAL, '0, word_t'(CODE_N - 1));
    send_instr(CMD_INT, '0, 32'd5);
    send_instr(CMD_OPR, '0, OPR_RET);
    send_instr(CMD_JMP, 4'd15, word_t'(CODE_N));
    send_instr(CMD_JMP, '0, 32'h8000_0000);
    send_instr(CMD_LIT, '0, '0);
    send_instr(CMD_JPC, '0, 32'd0);
    send_instr(CMD_JMP, '0, word_t'(CODE_N - 1));
    send_instr(CMD_INT, '0, 32'd1);
  endtask

  // The receiver stalls for a long stretch while the sender keeps offering.
  initial begin
    recv_hold = 0;
    wait (sb != null && sb.executed > 120);
    @(posedge clk);
    recv_hold = 1;
    repeat (400) @(posedge clk);
    recv_hold = 0;
  end

  initial begin
    sb = new();
    sb.clear_state();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst_n <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.cmd <= CMD_LIT;
    in_chan.level <= '0;
    in_chan.operand <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_directed();
    send_idle_pct = 19;
    recv_idle_pct = 72;
    repeat (500) send_random_instr();
    send_idle_pct = 72;
    recv_idle_pct = 19;
    repeat (500) send_random_instr();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (500) send_random_instr();
    in_chan.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Executed %0d instructions, checked %0d results.", sb.executed, sb.checked);
    $display("Faults seen: range %0d, divide %0d, jump %0d.", sb.fault_hits[FAULT_RANGE],
             sb.fault_hits[FAULT_DIV0], sb.fault_hits[FAULT_JUMP]);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("pcode_stack_machine_execute verification clean");
    end else begin
      $display("pcode_stack_machine_execute verification failed");
    end
    $finish;
  end
endmodule
